// ----- rtl/core/sha1_pkg.sv -----
package sha1_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned Words  = 5;
  localparam int unsigned Rounds = 80;

  localparam logic [WordW-1:0] IvWords [Words] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam logic [WordW-1:0] K0 = 32'h5A827999;
  localparam logic [WordW-1:0] K1 = 32'h6ED9EBA1;
  localparam logic [WordW-1:0] K2 = 32'h8F1BBCDC;
  localparam logic [WordW-1:0] K3 = 32'hCA62C1D6;

  localparam logic [7:0] PadByte = 8'h80;

  // Control from the sequencer to the message schedule line.
  typedef struct packed {
    logic       push;     // take one message byte
    logic [7:0] data;     // the byte
    logic [1:0] pos_lo;   // byte slot inside its word
    logic       step;     // advance one round
  } sch_ctl_t;

  // Control from the sequencer to the round unit.
  typedef struct packed {
    logic       start;    // load working words from the chain
    logic       step;     // run one round
    logic       fold;     // add working words into the chain
    logic       clear;    // return the chain to its initial value
    logic [6:0] round;    // round number
    logic [2:0] sel;      // digest word to show
  } rnd_ctl_t;

  function automatic logic [WordW-1:0] rotl1(input logic [WordW-1:0] v);
    return {v[WordW-2:0], v[WordW-1]};
  endfunction

endpackage

// ----- rtl/core/sha1_sched.sv -----
module sha1_sched (
  input  logic                     clk_i,
  input  sha1_pkg::sch_ctl_t       ctl_i,
  output logic [sha1_pkg::WordW-1:0] w_o
);
  import sha1_pkg::*;

  // Window holds W[t] .. W[t+15]; entry 0 is the current round's word.
  logic [WordW-1:0] win_q [16];
  logic [WordW-1:0] new_word;
  logic [23:0]      acc_q;
  logic             shift;

  assign shift    = ctl_i.step || (ctl_i.push && (ctl_i.pos_lo == 2'd3));
  assign new_word = ctl_i.step ? rotl1(win_q[13] ^ win_q[8] ^ win_q[2] ^ win_q[0])
                               : {acc_q, ctl_i.data};
  assign w_o      = win_q[0];

  always_ff @(posedge clk_i) begin
    if (ctl_i.push) begin
      acc_q <= {acc_q[15:0], ctl_i.data};
    end
    if (shift) begin
      for (int i = 0; i < 15; i++) begin
        win_q[i] <= win_q[i+1];
      end
      win_q[15] <= new_word;
    end
  end

endmodule

// ----- rtl/core/sha1_round.sv -----
module sha1_round (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  sha1_pkg::rnd_ctl_t         ctl_i,
  input  logic [sha1_pkg::WordW-1:0] w_i,
  output logic [sha1_pkg::WordW-1:0] word_o
);
  import sha1_pkg::*;

  logic [WordW-1:0] chain_q [Words];
  logic [WordW-1:0] a_q, b_q, c_q, d_q, e_q;
  logic [WordW-1:0] f, k, tmp;

  always_comb begin
    if (ctl_i.round < 7'd20) begin
      f = (b_q & c_q) | (~b_q & d_q);
      k = K0;
    end else if (ctl_i.round < 7'd40) begin
      f = b_q ^ c_q ^ d_q;
      k = K1;
    end else if (ctl_i.round < 7'd60) begin
      f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
      k = K2;
    end else begin
      f = b_q ^ c_q ^ d_q;
      k = K3;
    end
  end

  assign tmp = {a_q[26:0], a_q[31:27]} + f + e_q + k + w_i;

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      a_q <= chain_q[0];
      b_q <= chain_q[1];
      c_q <= chain_q[2];
      d_q <= chain_q[3];
      e_q <= chain_q[4];
    end else if (ctl_i.step) begin
      a_q <= tmp;
      b_q <= a_q;
      c_q <= {b_q[1:0], b_q[31:2]};
      d_q <= c_q;
      e_q <= d_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q <= IvWords;
    end else if (ctl_i.clear) begin
      chain_q <= IvWords;
    end else if (ctl_i.fold) begin
      chain_q[0] <= chain_q[0] + a_q;
      chain_q[1] <= chain_q[1] + b_q;
      chain_q[2] <= chain_q[2] + c_q;
      chain_q[3] <= chain_q[3] + d_q;
      chain_q[4] <= chain_q[4] + e_q;
    end
  end

  always_comb begin
    case (ctl_i.sel)
      3'd0:    word_o = chain_q[0];
      3'd1:    word_o = chain_q[1];
      3'd2:    word_o = chain_q[2];
      3'd3:    word_o = chain_q[3];
      default: word_o = chain_q[4];
    endcase
  end

endmodule

// ----- rtl/core/sha1_hash_core.sv -----
// A beat that fills the 64-byte block starts 80 rounds on the shared round unit and then
//   a fold into the chain; a beat that does not fill a block is taken without a block run.
// End of message: the padding bytes are pushed and each padded block is hashed,
//   then five digest beats, one per cycle while the sink takes them.
// No input beat is taken while a block is padded or hashed or the digest goes out.
// Reset (rst_ni low, async): chain to the initial vector, counters to zero, idle.
module sha1_hash_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tuser_i,   // [0] byte_valid
  input  logic        s_axis_tlast_i,   // end_of_message
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [31:0] digest_word
  output logic        m_axis_tlast_o    // word_last
);
  import sha1_pkg::*;

  // Sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;  // wait for a beat
  localparam logic [2:0] S_PAD   = 3'd1;  // push the 0x80 marker
  localparam logic [2:0] S_ZERO  = 3'd2;  // zero fill up to byte 56
  localparam logic [2:0] S_LEN   = 3'd3;  // push the 64-bit length, MSB first
  localparam logic [2:0] S_ROUND = 3'd4;  // 80 rounds on the shared unit
  localparam logic [2:0] S_ADD   = 3'd5;  // fold working words into the chain
  localparam logic [2:0] S_OUT   = 3'd6;  // hand out the five digest words

  logic [2:0]  state_q, state_d;
  logic [2:0]  ret_q, ret_d;       // where to go once a block is done
  logic [5:0]  pos_q, pos_d;       // byte slot in the current block
  logic [63:0] bitlen_q, bitlen_d;
  logic [6:0]  round_q, round_d;
  logic [2:0]  out_q, out_d;

  logic        in_fire, out_fire;
  logic        push, full;
  logic [7:0]  push_byte;
  logic [63:0] len_sh;
  logic [2:0]  after;              // state after this push when no block runs

  sch_ctl_t    sch_ctl;
  rnd_ctl_t    rnd_ctl;
  logic [WordW-1:0] w;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = (state_q == S_OUT);
  assign m_axis_tlast_o  = (out_q == 3'd4);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign out_fire        = m_axis_tvalid_o && m_axis_tready_i;

  // Length bytes go out most significant first: byte slot 56 carries bits 63:56.
  assign len_sh = bitlen_q >> {~pos_q[2:0], 3'b000};

  always_comb begin
    push      = 1'b0;
    push_byte = 8'h00;
    after     = state_q;
    unique case (state_q)
      S_IDLE: begin
        push      = in_fire && s_axis_tuser_i;
        push_byte = s_axis_tdata_i;
        after     = (in_fire && s_axis_tlast_i) ? S_PAD : S_IDLE;
      end
      S_PAD: begin
        push      = 1'b1;
        push_byte = PadByte;
        after     = S_ZERO;
      end
      S_ZERO: begin
        push      = (pos_q != 6'd56);
        push_byte = 8'h00;
        after     = S_ZERO;
      end
      S_LEN: begin
        push      = 1'b1;
        push_byte = len_sh[7:0];
        after     = S_LEN;
      end
      default: begin
        push      = 1'b0;
        push_byte = 8'h00;
        after     = state_q;
      end
    endcase
  end

  assign full = push && (pos_q == 6'd63);

  always_comb begin
    state_d  = state_q;
    ret_d    = ret_q;
    pos_d    = push ? pos_q + 6'd1 : pos_q;
    bitlen_d = (in_fire && s_axis_tuser_i) ? bitlen_q + 64'd8 : bitlen_q;
    round_d  = round_q;
    out_d    = out_q;
    unique case (state_q) inside
      S_IDLE, S_PAD, S_LEN: begin
        if (full) begin
          // A full block runs the rounds; after the last length byte the digest comes next.
          state_d = S_ROUND;
          ret_d   = (state_q == S_LEN) ? S_OUT : after;
        end else begin
          state_d = after;
        end
      end
      S_ZERO: begin
        if (!push) begin
          state_d = S_LEN;
        end else if (full) begin
          state_d = S_ROUND;
          ret_d   = S_ZERO;
        end
      end
      S_ROUND: begin
        if (round_q == 7'(Rounds - 1)) begin
          round_d = 7'd0;
          state_d = S_ADD;
        end else begin
          round_d = round_q + 7'd1;
        end
      end
      S_ADD: begin
        state_d = ret_q;
      end
      S_OUT: begin
        if (out_fire) begin
          if (out_q == 3'd4) begin
            // Drop all message state for the next message.
            out_d    = 3'd0;
            bitlen_d = 64'd0;
            pos_d    = 6'd0;
            state_d  = S_IDLE;
          end else begin
            out_d = out_q + 3'd1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ret_q    <= S_IDLE;
      pos_q    <= 6'd0;
      bitlen_q <= 64'd0;
      round_q  <= 7'd0;
      out_q    <= 3'd0;
    end else begin
      state_q  <= state_d;
      ret_q    <= ret_d;
      pos_q    <= pos_d;
      bitlen_q <= bitlen_d;
      round_q  <= round_d;
      out_q    <= out_d;
    end
  end

  assign sch_ctl.push   = push;
  assign sch_ctl.data   = push_byte;
  assign sch_ctl.pos_lo = pos_q[1:0];
  assign sch_ctl.step   = (state_q == S_ROUND);

  assign rnd_ctl.start  = full;
  assign rnd_ctl.step   = (state_q == S_ROUND);
  assign rnd_ctl.fold   = (state_q == S_ADD);
  assign rnd_ctl.clear  = out_fire && m_axis_tlast_o;
  assign rnd_ctl.round  = round_q;
  assign rnd_ctl.sel    = out_q;

  sha1_sched u_sched (
    .clk_i (clk_i),
    .ctl_i (sch_ctl),
    .w_o   (w)
  );

  sha1_round u_round (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (rnd_ctl),
    .w_i    (w),
    .word_o (m_axis_tdata_o)
  );

  // A block only runs once its byte slot has wrapped back to zero.
  a_round_pos : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ROUND) |-> (pos_q == 6'd0))
    else $error("round started with a partial block");

  // Input and output sides never open at once.
  a_one_side : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> !m_axis_tvalid_o)
    else $error("input taken during digest output");

  // Length bytes always sit in the top eight slots of a block.
  a_len_slot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LEN) |-> (pos_q[5:3] == 3'b111))
    else $error("length byte outside slots 56..63");

  // The last digest beat leaves a clean core.
  a_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && m_axis_tlast_o) |=> (state_q == S_IDLE && bitlen_q == 64'd0
                                      && pos_q == 6'd0))
    else $error("message state not cleared after digest");

endmodule
